### hw/rtl/lifo_stack_with_search_defines.svh
// assertion macros shared by the stack logic
`ifndef LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LSS_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lifo stack check failed");

// next-cycle implication, checked out of reset
`define LSS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lifo stack check failed");

`endif

### hw/rtl/lss_pkg.sv
// types, sizes and codes of the lifo stack with search
`timescale 1ns / 1ps

package lss_pkg;

   localparam int DEPTH  = 64;
   localparam int AW     = $clog2(DEPTH);
   localparam int CW     = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int POS_W  = 7;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;
   localparam logic [1:0] OP_SEARCH = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] word;
      logic [POS_W-1:0]         position;
      logic                     last;
   } rsp_type;

endpackage

### hw/rtl/lss_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module lss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### hw/rtl/lifo_stack_with_search.sv
// Last-in-first-out stack of signed 32-bit words with pop, dump and search.
// One request is taken at a time; the next is accepted once the last word of
// the current one sits in the output register. Push is accepted, then its
// result leaves from the emit state. Pop addresses the top entry at the
// accepting edge, and the entry comes out of the stack ram in the following
// cycle. Dump walks the ram from top to bottom, one entry per cycle while the
// output is not stalled. Search compares one entry per cycle from the top
// and stops at the first match.
`timescale 1ns / 1ps
`include "lifo_stack_with_search_defines.svh"

module lifo_stack_with_search (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  lss_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output lss_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type                      state_ff, state_in;
   logic [lss_pkg::CW-1:0]         count_ff, count_in;
   logic [lss_pkg::AW-1:0]         ptr_ff, ptr_in;
   logic [lss_pkg::CW-1:0]         pos_ff, pos_in;
   logic [1:0]                     op_ff, op_in;
   logic signed [lss_pkg::WORD_W-1:0] target_ff, target_in;
   lss_pkg::rsp_type               pend_ff, pend_in;
   lss_pkg::rsp_type               rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic                           req_fire;
   logic                           rsp_free;
   logic                           mem_we;
   logic [lss_pkg::WORD_W-1:0]     mem_rdata;
   logic signed [lss_pkg::WORD_W-1:0] top_word;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign top_word  = mem_rdata;

   // read address follows the next pointer so the data lines up with ptr_ff
   lss_ram #(
      .WIDTH(lss_pkg::WORD_W),
      .DEPTH(lss_pkg::DEPTH)
   ) u_ram (
      .clock(clock),
      .we(mem_we),
      .waddr(count_ff[lss_pkg::AW-1:0]),
      .wdata(req_data.value),
      .raddr(ptr_in),
      .rdata(mem_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      op_in        = op_ff;
      target_in    = target_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in              = req_data.op;
               target_in          = req_data.value;
               pos_in             = lss_pkg::CW'(1);
               ptr_in             = lss_pkg::AW'(count_ff - 1'b1);
               pend_in.status     = lss_pkg::ST_OK;
               pend_in.word       = '0;
               pend_in.position   = '0;
               pend_in.last       = 1'b1;
               if (req_data.op == lss_pkg::OP_PUSH) begin
                  state_in = S_EMIT;
                  if (count_ff == lss_pkg::CW'(lss_pkg::DEPTH)) begin
                     pend_in.status = lss_pkg::ST_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  pend_in.status = lss_pkg::ST_EMPTY;
                  state_in       = S_EMIT;
               end else begin
                  state_in = S_SCAN;
                  if (req_data.op == lss_pkg::OP_POP) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
         end
         S_SCAN: begin
            case (op_ff)
               lss_pkg::OP_POP: begin
                  if (rsp_free) begin
                     rsp_in.status   = lss_pkg::ST_OK;
                     rsp_in.word     = top_word;
                     rsp_in.position = '0;
                     rsp_in.last     = 1'b1;
                     rsp_valid_in    = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               lss_pkg::OP_DUMP: begin
                  if (rsp_free) begin
                     rsp_in.status   = lss_pkg::ST_OK;
                     rsp_in.word     = top_word;
                     rsp_in.position = '0;
                     rsp_in.last     = (ptr_ff == '0);
                     rsp_valid_in    = 1'b1;
                     if (ptr_ff == '0) begin
                        state_in = S_IDLE;
                     end else begin
                        ptr_in = ptr_ff - 1'b1;
                     end
                  end
               end
               lss_pkg::OP_SEARCH: begin
                  // first match from the top wins
                  if (top_word == target_ff) begin
                     pend_in.position = lss_pkg::POS_W'(pos_ff);
                     state_in         = S_EMIT;
                  end else if (ptr_ff == '0) begin
                     pend_in.status = lss_pkg::ST_NOTFOUND;
                     state_in       = S_EMIT;
                  end else begin
                     ptr_in = ptr_ff - 1'b1;
                     pos_in = pos_ff + 1'b1;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      op_ff     <= op_in;
      target_ff <= target_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   `LSS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= lss_pkg::CW'(lss_pkg::DEPTH))
   `LSS_ASSERT_NEXT(a_push_grows, clock, reset,
      req_fire && req_data.op == lss_pkg::OP_PUSH
         && count_ff != lss_pkg::CW'(lss_pkg::DEPTH),
      count_ff == $past(count_ff) + 1'b1)
   `LSS_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == S_SCAN,
      lss_pkg::CW'(ptr_ff) <= count_ff)

endmodule
